FILE: sv/npd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the nearest point distance block.
// No dependencies; imported by every other file of the block.
package npd_pkg;

  // Fixed field widths of the command and configuration ports.
  localparam int COUNT_BITS = 11;
  localparam int SLOT_BITS  = 10;

  // Defaults for the top level parameters.
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_COORD_BITS  = 24;

  // Command codes of an input transaction.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Control that travels with a squared distance down the root chain.
  typedef struct packed {
    logic valid;
    logic empty;
    logic last;
  } root_ctl_t;

endpackage

FILE: sv/nearest_point_distance.sv
`timescale 1ns / 1ps
// Top level of the nearest point distance block: table scan plus root chain.
// Depends on npd_pkg, npd_scan and npd_root_cell.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------------------
//  command  | start, busy               | command, slot, pos_x, pos_y, last_query
//  result   | done (one-cycle strobe)   | distance, empty_table, last_result
//  config   | cfg_write                 | cfg_data (coast_count)
//
// A load transaction gives no result.
// A query over N = min(coast_count, TABLE_DEPTH) points holds busy while the table
// port reads one point per cycle and while a four-stage distance pipeline drains.
// Its result then passes the result register and the root chain; the root chain
// has one cell per result bit, so a new query scans while the last one finishes.
// An empty table answers through the result register and the root chain without raising busy.
// Reset is synchronous and clears control only; table contents are kept.
module nearest_point_distance import npd_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [SLOT_BITS-1:0]         slot,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic                         last_query,
  input  logic                         cfg_write,
  input  logic [COUNT_BITS-1:0]        cfg_data,
  output logic                         done,
  output logic [COORD_BITS:0]          distance,
  output logic                         empty_table,
  output logic                         last_result
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int SQW  = 2 * COORD_BITS + 1;
  localparam int RW   = COORD_BITS + 1;

  logic [COUNT_BITS-1:0] coast_count;
  logic [CNTW-1:0]       count_sat;
  logic                  accept, query, load;

  root_ctl_t          ctl_w  [RW+1];
  logic [SQW-1:0]     rem_w  [RW+1];
  logic [RW-1:0]      root_w [RW+1];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      coast_count <= '0;
    end else if (cfg_write) begin
      coast_count <= cfg_data;
    end
  end

  // Transaction decode, slot range check and count saturation.
  always_comb begin
    accept    = start && !busy;
    query     = accept && (command == CMD_QUERY);
    load      = accept && (command == CMD_LOAD) && (32'(slot) < 32'(TABLE_DEPTH));
    count_sat = (32'(coast_count) > 32'(TABLE_DEPTH)) ? CNTW'(TABLE_DEPTH)
                                                      : CNTW'(coast_count);
  end

  npd_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .query    (query),
    .qx_in    (pos_x),
    .qy_in    (pos_y),
    .last_in  (last_query),
    .count_in (count_sat),
    .wr_en    (load),
    .wr_addr  (AW'(slot)),
    .wr_x     (pos_x),
    .wr_y     (pos_y),
    .busy     (busy),
    .res_ctl  (ctl_w[0]),
    .res_sum  (rem_w[0])
  );

  assign root_w[0] = '0;

  // Root chain: cell k settles root bit RW-1-k.
  for (genvar k = 0; k < RW; k++) begin : g_root
    npd_root_cell #(
      .COORD_BITS (COORD_BITS),
      .BIT        (RW - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_w[k]),
      .rem_in   (rem_w[k]),
      .root_in  (root_w[k]),
      .ctl_out  (ctl_w[k+1]),
      .rem_out  (rem_w[k+1]),
      .root_out (root_w[k+1])
    );
  end

  // Result ports come straight from the last cell's registers.
  assign done        = ctl_w[RW].valid;
  assign distance    = root_w[RW];
  assign empty_table = ctl_w[RW].empty;
  assign last_result = ctl_w[RW].last;

  // Busy only rises after a query transaction.
  a_busy_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(query))
    else $error("busy rose without a query");

endmodule

FILE: sv/npd_root_cell.sv
`timescale 1ns / 1ps
// One cell of the square root chain: decides one root bit per cycle.
// Depends on npd_pkg for the control struct.
module npd_root_cell import npd_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int BIT        = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  root_ctl_t                 ctl_in,
  input  logic [2*COORD_BITS:0]     rem_in,
  input  logic [COORD_BITS:0]       root_in,
  output root_ctl_t                 ctl_out,
  output logic [2*COORD_BITS:0]     rem_out,
  output logic [COORD_BITS:0]       root_out
);

  localparam int RW  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS + 1;
  localparam int TW  = 2 * RW + 1;

  logic [TW-1:0] rem_wide;
  logic [TW-1:0] trial;
  logic          take;

  // Growing the root by this bit adds 2*root*2^BIT + 2^(2*BIT) to its square.
  always_comb begin
    rem_wide = TW'(rem_in);
    trial    = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    take     = (trial <= rem_wide);
  end

  // Control moves on every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // Remainder and partial root need no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      rem_out  <= SQW'(rem_wide - trial);
      root_out <= root_in | (RW'(1) << BIT);
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in;
    end
  end

endmodule

FILE: sv/npd_scan.sv
`timescale 1ns / 1ps
// Point table and the scan pipeline that finds the smallest squared distance.
// Depends on npd_pkg; feeds the first cell of the root chain.
module npd_scan import npd_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNTW = $clog2(TABLE_DEPTH + 1),
  localparam int SQW  = 2 * COORD_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         query,
  input  logic signed [COORD_BITS-1:0] qx_in,
  input  logic signed [COORD_BITS-1:0] qy_in,
  input  logic                         last_in,
  input  logic [CNTW-1:0]              count_in,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [COORD_BITS-1:0]        wr_x,
  input  logic [COORD_BITS-1:0]        wr_y,
  output logic                         busy,
  output root_ctl_t                    res_ctl,
  output logic [SQW-1:0]               res_sum
);

  localparam int C  = COORD_BITS;
  localparam logic [63:0] SPAN = (64'd1 << COORD_BITS) - 64'd1;
  localparam logic [SQW-1:0] SPAN_SQ = SQW'((SPAN * SPAN) << 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } scan_state_t;

  typedef struct packed {
    logic valid;
    logic last_pt;
    logic first_pt;
  } tag_t;

  scan_state_t state, state_next;
  logic [CNTW-1:0] idx, idx_next, count;
  logic [C-1:0] qx, qy;
  logic q_last;

  logic [C-1:0] ref_x [TABLE_DEPTH];
  logic [C-1:0] ref_y [TABLE_DEPTH];

  tag_t t0, t1, t2, t3, t4;
  logic [C-1:0] mem_x, mem_y;
  logic [C-1:0] dx, dy;
  logic [2*C-1:0] sqx, sqy;
  logic [SQW-1:0] sum4, best, pick;
  logic [C:0] dxf, dyf, dxa, dya;

  assign busy = (state != ST_IDLE);

  // Scan sequencer: issues one table read per cycle while scanning.
  always_comb begin
    state_next  = state;
    idx_next    = idx + 1'b1;
    t0.valid    = (state == ST_SCAN);
    t0.last_pt  = (idx_next == count);
    t0.first_pt = (idx == '0);
    unique case (state)
      ST_IDLE: begin
        if (query && count_in != '0) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_next == count) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (t4.valid && t4.last_pt) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        idx <= idx_next;
      end else begin
        idx <= '0;
      end
    end
  end

  // Query operands are held for the whole scan.
  always_ff @(posedge clk) begin
    if (query && !busy) begin
      qx     <= qx_in;
      qy     <= qy_in;
      q_last <= last_in;
      count  <= count_in;
    end
  end

  // Point table: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_x[wr_addr] <= wr_x;
      ref_y[wr_addr] <= wr_y;
    end
    mem_x <= ref_x[idx[AW-1:0]];
    mem_y <= ref_y[idx[AW-1:0]];
  end

  // Absolute coordinate differences and the running minimum select.
  always_comb begin
    dxf = {qx[C-1], qx} - {mem_x[C-1], mem_x};
    dyf = {qy[C-1], qy} - {mem_y[C-1], mem_y};
    dxa = dxf[C] ? (~dxf + 1'b1) : dxf;
    dya = dyf[C] ? (~dyf + 1'b1) : dyf;
    pick = (t4.first_pt || sum4 < best) ? sum4 : best;
  end

  // Tags follow the data through the pipeline stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
    end else begin
      t1 <= t0;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
    end
  end

  // Difference, square and sum stages, then the running minimum.
  always_ff @(posedge clk) begin
    dx   <= dxa[C-1:0];
    dy   <= dya[C-1:0];
    sqx  <= dx * dx;
    sqy  <= dy * dy;
    sum4 <= SQW'(sqx) + SQW'(sqy);
    if (t4.valid) best <= pick;
  end

  // Result handed to the root chain; an empty table sends the largest span.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctl <= '0;
    end else if (query && !busy && count_in == '0) begin
      res_ctl <= '{valid: 1'b1, empty: 1'b1, last: last_in};
    end else if (t4.valid && t4.last_pt) begin
      res_ctl <= '{valid: 1'b1, empty: 1'b0, last: q_last};
    end else begin
      res_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (query && !busy && count_in == '0) begin
      res_sum <= SPAN_SQ;
    end else if (t4.valid && t4.last_pt) begin
      res_sum <= pick;
    end
  end

  // The table is never written while a scan is in flight.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_IDLE)
    else $error("table write during scan");

  // The read index stays inside the scanned range.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx < count)
    else $error("scan index beyond count");

  // The final point of a scan always yields a result.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    t4.valid && t4.last_pt |=> res_ctl.valid && !res_ctl.empty)
    else $error("scan end without result");

endmodule
